// File: design/biq_pkg.sv
// shared types and constants for the biquad filter
package biq_pkg;

  localparam int COEF_BITS      = 24;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;
  localparam int STEP_BITS      = 3;
  localparam logic [STEP_BITS-1:0] LAST_STEP = 3'd7;

  localparam logic signed [COEF_BITS-1:0] B0_RESET = 24'sd2097152;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_FORM = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ACC_HOLD     = 3'd0,
    ACC_LOAD     = 3'd1,
    ACC_LOAD_ADD = 3'd2,
    ACC_ADD      = 3'd3,
    ACC_SUB      = 3'd4
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

endpackage

// File: design/biq_if.sv
// valid/ready channel interfaces for samples, results and configuration
interface biq_in_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          clear_state;

  modport source (output valid, sample, clear_state, input ready);
  modport sink (input valid, sample, clear_state, output ready);
endinterface

interface biq_out_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          saturated;

  modport source (output valid, filtered, saturated, input ready);
  modport sink (input valid, filtered, saturated, output ready);
endinterface

interface biq_cfg_if import biq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/biq_mac.sv
// shared multiply-accumulate unit with output rounding and delay clipping
module biq_mac import biq_pkg::*; #(
  parameter int SAMPLE_BITS    = 16,
  parameter int COEF_FRAC_BITS = 21
) (
  input  logic                                    clk,
  input  mac_ctrl_t                               ctrl,
  input  logic signed [COEF_BITS-1:0]             coef,
  input  logic signed [SAMPLE_BITS-1:0]           data,
  input  logic signed [SAMPLE_BITS+COEF_BITS-1:0] ld,
  output logic signed [SAMPLE_BITS-1:0]           y_round,
  output logic                                    y_hit,
  output logic signed [SAMPLE_BITS+COEF_BITS-1:0] d_clip,
  output logic                                    d_hit
);

  localparam int DELAY_BITS = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS   = DELAY_BITS + 4;
  localparam logic signed [ACC_BITS-1:0] HALF =
    ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [DELAY_BITS-1:0] prod;
  logic signed [ACC_BITS-1:0]   acc;
  logic signed [ACC_BITS-1:0]   prod_ext;
  logic signed [ACC_BITS-1:0]   ld_ext;
  logic signed [ACC_BITS-1:0]   rnd_sum;
  logic signed [ACC_BITS-1:0]   shifted;
  logic [ACC_BITS-SAMPLE_BITS:0] y_upper;
  logic [ACC_BITS-DELAY_BITS:0]  d_upper;
  logic                          y_fits;
  logic                          d_fits;

  assign prod_ext = ACC_BITS'(prod);
  assign ld_ext   = ACC_BITS'(ld);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= coef * data;
    end
    case (ctrl.acc_op)
      ACC_HOLD:     acc <= acc;
      ACC_LOAD:     acc <= ld_ext;
      ACC_LOAD_ADD: acc <= ld_ext + prod_ext;
      ACC_ADD:      acc <= acc + prod_ext;
      ACC_SUB:      acc <= acc - prod_ext;
      default:      acc <= acc;
    endcase
  end

  // add half, floor shift, saturate to sample width
  assign rnd_sum = acc + HALF;
  assign shifted = rnd_sum >>> COEF_FRAC_BITS;
  assign y_upper = shifted[ACC_BITS-1:SAMPLE_BITS-1];
  assign y_fits  = (&y_upper) | ~(|y_upper);
  assign y_hit   = ~y_fits;

  always_comb begin
    if (y_fits) begin
      y_round = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[ACC_BITS-1]) begin
      y_round = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_round = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // accumulator delay saturation
  assign d_upper = acc[ACC_BITS-1:DELAY_BITS-1];
  assign d_fits  = (&d_upper) | ~(|d_upper);
  assign d_hit   = ~d_fits;

  always_comb begin
    if (d_fits) begin
      d_clip = acc[DELAY_BITS-1:0];
    end else if (acc[ACC_BITS-1]) begin
      d_clip = {1'b1, {(DELAY_BITS-1){1'b0}}};
    end else begin
      d_clip = {1'b0, {(DELAY_BITS-1){1'b1}}};
    end
  end

endmodule

// File: design/biquad_iir_filter_top.sv
// biquad iir filter section, top level with sequencer and state
//
// feed carries one signed sample word with a clear_state bit; result returns
// one filtered word with a saturated flag; cfg writes coefficient registers
// b0, b1, b2, a1, a2 (signed q2.frac) and form_select (0 transposed df2,
// 1 df1). cfg is always ready; the user must write it only while the filter
// is idle, as the block itself does not enforce it. after a word is accepted
// the filter runs eight steps of one shared multiplier and accumulator, five
// products per sample; result.valid rises once the last step finishes and
// feed is ready again in that same cycle, so no new word is taken while one
// is running. clear_state zeroes all delays before its word is filtered.
// result is held in an output register; a new word is taken while it waits,
// and the last step waits for the receiver if the register is still full.
// reset (synchronous, active high) loads b0 = 1.0, the other registers and
// all delays to zero, and empties the output register.
module biquad_iir_filter_top import biq_pkg::*; #(
  parameter int COEF_FRAC_BITS = 21,
  parameter int SAMPLE_BITS    = 16
) (
  input logic     clk,
  input logic     rst,
  biq_in_if.sink  feed,
  biq_out_if.source result,
  biq_cfg_if.sink cfg
);

  localparam int DELAY_BITS = SAMPLE_BITS + COEF_BITS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                 state;
  logic [STEP_BITS-1:0]   step;
  logic                   accept;
  logic                   last;
  logic                   finish;

  logic signed [COEF_BITS-1:0] coef_b0;
  logic signed [COEF_BITS-1:0] coef_b1;
  logic signed [COEF_BITS-1:0] coef_b2;
  logic signed [COEF_BITS-1:0] coef_a1;
  logic signed [COEF_BITS-1:0] coef_a2;
  logic                        form_sel;

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                          hit;
  logic signed [DELAY_BITS-1:0]  d1;
  logic signed [DELAY_BITS-1:0]  d2;
  logic signed [SAMPLE_BITS-1:0] y1;
  logic signed [SAMPLE_BITS-1:0] y2;
  logic signed [SAMPLE_BITS-1:0] x1;
  logic signed [SAMPLE_BITS-1:0] x2;

  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          saturated;
  logic                          out_valid;
  logic                          sat_final;

  mac_ctrl_t                     ctrl;
  logic signed [COEF_BITS-1:0]   mul_coef;
  logic signed [SAMPLE_BITS-1:0] mul_data;
  logic signed [DELAY_BITS-1:0]  ld;
  logic signed [SAMPLE_BITS-1:0] y_round;
  logic                          y_hit;
  logic signed [DELAY_BITS-1:0]  d_clip;
  logic                          d_hit;

  assign feed.ready = (state == ST_IDLE);
  assign accept     = feed.valid && feed.ready;
  assign last       = (state == ST_RUN) && (step == LAST_STEP);
  assign finish     = last && (!out_valid || result.ready);

  assign cfg.ready  = 1'b1;

  assign result.valid     = out_valid;
  assign result.filtered  = filtered;
  assign result.saturated = saturated;

  assign x1 = d1[SAMPLE_BITS-1:0];
  assign x2 = d2[SAMPLE_BITS-1:0];
  assign sat_final = form_sel ? hit : (hit | d_hit);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0  <= B0_RESET;
      coef_b1  <= '0;
      coef_b2  <= '0;
      coef_a1  <= '0;
      coef_a2  <= '0;
      form_sel <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_B0:   coef_b0  <= cfg.data;
        REG_B1:   coef_b1  <= cfg.data;
        REG_B2:   coef_b2  <= cfg.data;
        REG_A1:   coef_a1  <= cfg.data;
        REG_A2:   coef_a2  <= cfg.data;
        REG_FORM: form_sel <= cfg.data[0];
        default:  ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (step != LAST_STEP) begin
            step <= step + 3'd1;
          end else if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // operand selection per step
  always_comb begin
    ctrl.mul_en = 1'b0;
    ctrl.acc_op = ACC_HOLD;
    mul_coef    = coef_b0;
    mul_data    = x;
    ld          = '0;
    if (state == ST_RUN) begin
      if (!form_sel) begin
        case (step)
          3'd0: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_LOAD;
            ld          = d1;
          end
          3'd1: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_ADD;
            mul_coef    = coef_b1;
          end
          3'd2: begin
            ctrl.acc_op = ACC_LOAD_ADD;
            ld          = d2;
          end
          3'd3: begin
            ctrl.mul_en = 1'b1;
            mul_coef    = coef_a1;
            mul_data    = y;
          end
          3'd4: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_SUB;
            mul_coef    = coef_b2;
          end
          3'd5: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_LOAD_ADD;
            mul_coef    = coef_a2;
            mul_data    = y;
          end
          3'd6: ctrl.acc_op = ACC_SUB;
          default: ;
        endcase
      end else begin
        case (step)
          3'd0: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_LOAD;
          end
          3'd1: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_ADD;
            mul_coef    = coef_b1;
            mul_data    = x1;
          end
          3'd2: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_ADD;
            mul_coef    = coef_b2;
            mul_data    = x2;
          end
          3'd3: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_ADD;
            mul_coef    = coef_a1;
            mul_data    = y1;
          end
          3'd4: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_SUB;
            mul_coef    = coef_a2;
            mul_data    = y2;
          end
          3'd5: ctrl.acc_op = ACC_SUB;
          default: ;
        endcase
      end
    end
  end

  biq_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .ctrl    (ctrl),
    .coef    (mul_coef),
    .data    (mul_data),
    .ld      (ld),
    .y_round (y_round),
    .y_hit   (y_hit),
    .d_clip  (d_clip),
    .d_hit   (d_hit)
  );

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (accept) begin
      if (feed.clear_state) begin
        d1 <= '0;
        d2 <= '0;
        y1 <= '0;
        y2 <= '0;
      end
    end else if (state == ST_RUN) begin
      if (!form_sel) begin
        if (step == 3'd5) begin
          d1 <= d_clip;
        end
        if (finish) begin
          d2 <= d_clip;
        end
      end else if (finish) begin
        d1 <= {{(DELAY_BITS-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
        d2 <= {{(DELAY_BITS-SAMPLE_BITS){x1[SAMPLE_BITS-1]}}, x1};
        y1 <= y;
        y2 <= y1;
      end
    end
  end

  // sample, output and saturation flag
  always_ff @(posedge clk) begin
    if (accept) begin
      x   <= feed.sample;
      hit <= 1'b0;
    end else if (state == ST_RUN) begin
      if ((!form_sel && step == 3'd2) || (form_sel && step == 3'd6)) begin
        y   <= y_round;
        hit <= hit | y_hit;
      end else if (!form_sel && step == 3'd5) begin
        hit <= hit | d_hit;
      end
    end
    if (finish) begin
      filtered  <= y;
      saturated <= sat_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RUN) && (step == '0))
    else $error("sequencer did not start at step zero");

  a_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && (step != LAST_STEP) |=>
      (state == ST_RUN) && (step == STEP_BITS'($past(step) + 3'd1)))
    else $error("step counter did not advance");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    finish |=> result.valid && (state == ST_IDLE))
    else $error("finished word not presented");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    accept && feed.clear_state |=> (d1 == '0) && (d2 == '0) && (y1 == '0) && (y2 == '0))
    else $error("delays not cleared");

endmodule

// File: test/biquad_iir_filter_top_test.sv
`timescale 1ns / 100ps
// testbench for biquad_iir_filter_top: directed table, then randomized words checked by a model
module biquad_iir_filter_top_test import biq_pkg::*; ();

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W = 21;
  localparam int DELAY_W = SAMPLE_W + COEF_BITS;
  localparam longint HALF = longint'(1) <<< (FRAC_W - 1);
  localparam int CYCLE_LIMIT = 400000;
  localparam int STALL_CYCLES = 400;
  localparam int WORDS_PER_SETTING = 71;
  localparam int TABLE_ROWS = 38;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NONE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NONE_HI = 3'd7;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic                saturated;
  } out_word_t;

  typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  val;
    logic [SAMPLE_W-1:0]       smp;
    logic                      clr;
    logic                      typed;
    out_word_t                 ans;
  } step_row_t;

  logic clk;
  logic rst;

  biq_in_if #(.SAMPLE_BITS(SAMPLE_W)) feed ();
  biq_out_if #(.SAMPLE_BITS(SAMPLE_W)) result ();
  biq_cfg_if cfg ();

  biquad_iir_filter_top #(
    .COEF_FRAC_BITS(FRAC_W),
    .SAMPLE_BITS(SAMPLE_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .feed(feed),
    .result(result),
    .cfg(cfg)
  );

  // filter model state
  longint k_b0, k_b1, k_b2, k_a1, k_a2;
  logic   k_form;
  longint st_d1, st_d2, st_y1, st_y2;

  out_word_t pending_out[$];
  out_word_t got_word, want_word;
  int        miss_count;
  int        feed_idle_pct;
  int        drain_idle_pct;
  logic      stall_go;
  logic      hold_off;
  int        cycle_count;
  step_row_t steps [TABLE_ROWS];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint saturate(input longint v, input int bits, inout logic hit);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic out_word_t filter_step(input logic [SAMPLE_W-1:0] smp, input logic clr);
    longint    x, y, acc, x1, x2;
    logic      hit;
    out_word_t w;
    x = longint'($signed(smp));
    hit = 1'b0;
    if (clr) begin
      st_d1 = 0;
      st_d2 = 0;
      st_y1 = 0;
      st_y2 = 0;
    end
    if (k_form == 1'b0) begin
      y = saturate((k_b0 * x + st_d1 + HALF) >>> FRAC_W, SAMPLE_W, hit);
      st_d1 = saturate(k_b1 * x - k_a1 * y + st_d2, DELAY_W, hit);
      st_d2 = saturate(k_b2 * x - k_a2 * y, DELAY_W, hit);
    end else begin
      // input delays are read as their low sample bits after a form switch
      x1 = longint'($signed(st_d1[SAMPLE_W-1:0]));
      x2 = longint'($signed(st_d2[SAMPLE_W-1:0]));
      acc = k_b0 * x + k_b1 * x1 + k_b2 * x2 - k_a1 * st_y1 - k_a2 * st_y2;
      y = saturate((acc + HALF) >>> FRAC_W, SAMPLE_W, hit);
      st_d2 = x1;
      st_d1 = x;
      st_y2 = st_y1;
      st_y1 = y;
    end
    w.filtered = y[SAMPLE_W-1:0];
    w.saturated = hit;
    return w;
  endfunction

  function automatic void report_miss(input string what, input out_word_t want,
                                      input out_word_t got);
    miss_count++;
    if (miss_count <= 10) begin
      $display("mismatch on %s at %0t: expected filtered %0d saturated %0b, got %0d %0b",
               what, $realtime, $signed(want.filtered), want.saturated,
               $signed(got.filtered), got.saturated);
    end
  endfunction

  function automatic step_row_t typed_row(input logic [SAMPLE_W-1:0] smp, input logic clr,
                                          input logic [SAMPLE_W-1:0] f, input logic s);
    return '{ROW_WORD, REG_B0, '0, smp, clr, 1'b1, '{f, s}};
  endfunction

  function automatic step_row_t open_row(input logic [SAMPLE_W-1:0] smp, input logic clr);
    return '{ROW_WORD, REG_B0, '0, smp, clr, 1'b0, '{'0, 1'b0}};
  endfunction

  function automatic step_row_t reg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] val);
    return '{ROW_REG, idx, val, '0, 1'b0, 1'b0, '{'0, 1'b0}};
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_coef();
    case ($urandom_range(9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2, 3, 4, 5: return 24'(int'($urandom_range(4194304)) - 2097152);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(15))
      0: return 16'h7fff;
      1: return 16'h8000;
      2, 3: return 16'(int'($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // call right after the clock rises; returns once the word has been accepted
  task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic clr,
                           input logic typed, input out_word_t ans);
    out_word_t want;
    if ($urandom_range(99) < feed_idle_pct) begin
      feed.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < feed_idle_pct);
    end
    feed.valid <= 1'b1;
    feed.sample <= smp;
    feed.clear_state <= clr;
    do @(posedge clk); while (!feed.ready);
    want = filter_step(smp, clr);
    pending_out.push_back(typed ? ans : want);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_B0: k_b0 = longint'($signed(val));
      REG_B1: k_b1 = longint'($signed(val));
      REG_B2: k_b2 = longint'($signed(val));
      REG_A1: k_a1 = longint'($signed(val));
      REG_A2: k_a2 = longint'($signed(val));
      REG_FORM: k_form = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    feed.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  // mode 1 loads every coefficient at its top, mode 2 at its bottom
  task automatic program_filter(input int mode);
    logic [CFG_DATA_BITS-1:0] c [5];
    logic                     frm;
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      c[i] = mode == 1 ? 24'h7fffff : mode == 2 ? 24'h800000 : pick_coef();
    end
    frm = mode == 2 ? 1'b1 : mode == 1 ? 1'b0 : 1'($urandom_range(1));
    write_reg(REG_B0, c[0]);
    write_reg(REG_B1, c[1]);
    write_reg(REG_B2, c[2]);
    write_reg(REG_A1, c[3]);
    write_reg(REG_A2, c[4]);
    write_reg(REG_FORM, {23'd0, frm});
    cfg.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    result.ready <= !hold_off && ($urandom_range(99) >= drain_idle_pct);
  end

  initial begin
    hold_off = 1'b0;
    wait (stall_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      got_word = '{result.filtered, result.saturated};
      if (pending_out.size() == 0) begin
        report_miss("unexpected word", '0, got_word);
      end else begin
        want_word = pending_out.pop_front();
        if (want_word.filtered !== got_word.filtered) begin
          report_miss("filtered", want_word, got_word);
        end else if (want_word.saturated !== got_word.saturated) begin
          report_miss("saturated", want_word, got_word);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("biquad_iir_filter_top verification failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    feed.valid = 1'b0;
    feed.sample = '0;
    feed.clear_state = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_B0;
    cfg.data = '0;
    result.ready = 1'b0;
    stall_go = 1'b0;
    miss_count = 0;
    feed_idle_pct = 19;
    drain_idle_pct = 72;
    k_b0 = longint'(B0_RESET);
    k_b1 = 0;
    k_b2 = 0;
    k_a1 = 0;
    k_a2 = 0;
    k_form = 1'b0;
    st_d1 = 0;
    st_d2 = 0;
    st_y1 = 0;
    st_y2 = 0;
    steps = '{
      // unity gain after reset
      typed_row(16'h0000, 1'b0, 16'h0000, 1'b0),
      typed_row(16'h7fff, 1'b0, 16'h7fff, 1'b0),
      typed_row(16'h8000, 1'b0, 16'h8000, 1'b0),
      typed_row(16'h0001, 1'b0, 16'h0001, 1'b0),
      typed_row(16'hffff, 1'b1, 16'hffff, 1'b0),
      typed_row(16'h5555, 1'b0, 16'h5555, 1'b0),
      typed_row(16'haaaa, 1'b0, 16'haaaa, 1'b0),
      // output clipping at both gain extremes
      reg_row(REG_B0, 24'h7fffff),
      typed_row(16'h7fff, 1'b0, 16'h7fff, 1'b1),
      typed_row(16'h8000, 1'b0, 16'h8000, 1'b1),
      reg_row(REG_B0, 24'h800000),
      typed_row(16'h8000, 1'b0, 16'h7fff, 1'b1),
      typed_row(16'h7fff, 1'b0, 16'h8000, 1'b1),
      // accumulator delays driven into their bounds
      reg_row(REG_B1, 24'h800000),
      reg_row(REG_B2, 24'h800000),
      reg_row(REG_A1, 24'h800000),
      reg_row(REG_A2, 24'h800000),
      open_row(16'h8000, 1'b1),
      open_row(16'h8000, 1'b0),
      open_row(16'h7fff, 1'b0),
      open_row(16'h8000, 1'b0),
      open_row(16'h7fff, 1'b0),
      // form switch with delays kept
      reg_row(REG_FORM, 24'd1),
      open_row(16'd12345, 1'b0),
      open_row(16'h8000, 1'b0),
      open_row(16'h7fff, 1'b0),
      // writes to indexes past the last register are dropped
      reg_row(REG_NONE_LO, 24'hffffff),
      reg_row(REG_NONE_HI, 24'h000000),
      open_row(16'd100, 1'b1),
      reg_row(REG_B0, 24'd1048576),
      reg_row(REG_B1, 24'd2097152),
      reg_row(REG_B2, 24'd1048576),
      reg_row(REG_A1, 24'he00000),
      reg_row(REG_A2, 24'd524288),
      reg_row(REG_FORM, 24'd0),
      open_row(16'd20000, 1'b0),
      open_row(-16'sd20000, 1'b0),
      open_row(16'h0000, 1'b0)
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < TABLE_ROWS; i++) begin
      if (steps[i].kind == ROW_REG) begin
        if (i == 0 || steps[i-1].kind == ROW_WORD) wait_idle();
        write_reg(steps[i].idx, steps[i].val);
      end else begin
        cfg.valid <= 1'b0;
        send_word(steps[i].smp, steps[i].clr, steps[i].typed, steps[i].ans);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      feed_idle_pct = ph == 0 ? 19 : ph == 1 ? 72 : 0;
      drain_idle_pct = ph == 0 ? 72 : ph == 1 ? 19 : 0;
      for (int st = 0; st < 4; st++) begin
        program_filter(st != 0 ? 0 : ph == 0 ? 1 : ph == 1 ? 2 : 0);
        if (ph == 2 && st == 0) stall_go = 1'b1;
        repeat (WORDS_PER_SETTING) begin
          send_word(pick_sample(), 1'($urandom_range(19) == 0), 1'b0, '0);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (miss_count == 0 && pending_out.size() == 0) begin
      $display("biquad_iir_filter_top verification clean");
    end else begin
      $display("biquad_iir_filter_top verification failed");
    end
    $finish;
  end

endmodule
